>>> src/pcr_pkg.sv
// Package for the polar to Cartesian rotator: widths, CORDIC constants,
// the pipeline payload type and the per-iteration rotation function.
// No dependencies.
`default_nettype none

package pcr_pkg;

	// Field widths
	localparam int RW = 16;             // radius, unsigned Q8.8
	localparam int AW = 16;             // binary angle
	localparam int HW = 16;             // height, signed Q8.8
	localparam int OW = 17;             // x and y results, signed Q8.8

	// Datapath widths: vector carries 30 extra fraction bits, angle is in pi/2^31
	localparam int FRAC = 30;
	localparam int PW = RW + FRAC;      // radius times gain product
	localparam int DW = PW + 3;         // vector word, headroom for CORDIC growth
	localparam int ZW = AW + 17;        // angle accumulator
	localparam int ZSH = 16;            // folded angle enters shifted by this

	// Pipeline shape
	localparam int ITERS = 24;
	localparam int ITERS_PER_STG = 2;
	localparam int ROT_STGS = ITERS / ITERS_PER_STG;
	localparam int PIPE_DEPTH = ROT_STGS + 2;

	// Constants
	localparam logic [FRAC-1:0] GAIN_Q30 = 30'd652032874;
	localparam logic signed [AW-1:0] QUARTER_POS = 16'sd16384;
	localparam logic signed [AW-1:0] QUARTER_NEG = -16'sd16384;
	localparam logic signed [DW-1:0] RND_HALF = DW'(64'd1 << (FRAC - 1));
	localparam logic signed [DW-FRAC-1:0] OUT_MAX = (DW-FRAC)'(65535);
	localparam logic signed [DW-FRAC-1:0] OUT_MIN = -(DW-FRAC)'(65535);

	// One item on its way through the rotation stages
	typedef struct packed {
		logic signed [DW-1:0] x;
		logic signed [DW-1:0] y;
		logic signed [ZW-1:0] z;
		logic signed [HW-1:0] h;
	} rot_t;

	// atan(2^-i) in units of pi/2^31
	function automatic logic [ZW-1:0] atan_at(input int unsigned i);
		logic [ZW-1:0] v;
		unique case (i)
			0:  v = ZW'(536870912);
			1:  v = ZW'(316933406);
			2:  v = ZW'(167458907);
			3:  v = ZW'(85004756);
			4:  v = ZW'(42667331);
			5:  v = ZW'(21354465);
			6:  v = ZW'(10679838);
			7:  v = ZW'(5340245);
			8:  v = ZW'(2670163);
			9:  v = ZW'(1335087);
			10: v = ZW'(667544);
			11: v = ZW'(333772);
			12: v = ZW'(166886);
			13: v = ZW'(83443);
			14: v = ZW'(41722);
			15: v = ZW'(20861);
			16: v = ZW'(10430);
			17: v = ZW'(5215);
			18: v = ZW'(2608);
			19: v = ZW'(1304);
			20: v = ZW'(652);
			21: v = ZW'(326);
			22: v = ZW'(163);
			23: v = ZW'(81);
			default: v = '0;
		endcase
		return v;
	endfunction

	// One CORDIC rotation step; arithmetic shifts round toward minus infinity
	function automatic rot_t cordic_iter(input rot_t v, input int unsigned i);
		logic signed [DW-1:0] xv;
		logic signed [DW-1:0] yv;
		logic signed [DW-1:0] dx;
		logic signed [DW-1:0] dy;
		logic signed [ZW-1:0] zv;
		logic signed [ZW-1:0] av;
		rot_t r;
		xv = v.x;
		yv = v.y;
		zv = v.z;
		dx = yv >>> i;
		dy = xv >>> i;
		av = $signed(atan_at(i));
		r = v;
		if (!zv[ZW-1]) begin
			r.x = xv - dx;
			r.y = yv + dy;
			r.z = zv - av;
		end else begin
			r.x = xv + dx;
			r.y = yv - dy;
			r.z = zv + av;
		end
		return r;
	endfunction

	// Round half up from the extended fraction and keep inside +/-65535
	function automatic logic signed [OW-1:0] round_clamp(input logic signed [DW-1:0] v);
		logic signed [DW-1:0] s;
		logic signed [DW-FRAC-1:0] t;
		logic signed [OW-1:0] r;
		s = v + RND_HALF;
		t = s[DW-1:FRAC];
		if (t > OUT_MAX) begin
			r = OUT_MAX[OW-1:0];
		end else if (t < OUT_MIN) begin
			r = OUT_MIN[OW-1:0];
		end else begin
			r = t[OW-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> src/pcr_if.sv
// Stream interfaces of the polar to Cartesian rotator: the polar input
// channel and the Cartesian result channel. Depends on pcr_pkg.
`default_nettype none

interface pcr_polar_if
	import pcr_pkg::*;
;
	logic valid;
	logic ready;
	logic [RW-1:0] radius;
	logic signed [AW-1:0] angle;
	logic signed [HW-1:0] height;

	modport source (output valid, output radius, output angle, output height, input ready);
	modport sink (input valid, input radius, input angle, input height, output ready);
endinterface

interface pcr_cart_if
	import pcr_pkg::*;
;
	logic valid;
	logic ready;
	logic signed [OW-1:0] x_coord;
	logic signed [OW-1:0] y_coord;
	logic signed [HW-1:0] z_coord;

	modport source (output valid, output x_coord, output y_coord, output z_coord, input ready);
	modport sink (input valid, input x_coord, input y_coord, input z_coord, output ready);
endinterface

`default_nettype wire

>>> src/pcr_cordic.sv
// Rotation pipeline of the polar to Cartesian rotator: ROT_STGS register
// stages, each doing ITERS_PER_STG CORDIC iterations. Depends on pcr_pkg.
`default_nettype none

module pcr_cordic
	import pcr_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic up_valid,
	output logic      up_ready,
	input  wire rot_t up_data,
	output logic      dn_valid,
	input  wire logic dn_ready,
	output rot_t      dn_data
);

	logic vld_s  [ROT_STGS];
	rot_t data_s [ROT_STGS];
	logic rdy    [ROT_STGS];

	for (genvar k = 0; k < ROT_STGS; k++) begin : g_stg
		logic in_v;
		rot_t in_d;
		rot_t nxt_d;
		logic nxt_rdy;

		// stage input select
		if (k == 0) begin : g_first
			assign in_v = up_valid;
			assign in_d = up_data;
		end else begin : g_mid
			assign in_v = vld_s[k-1];
			assign in_d = data_s[k-1];
		end

		if (k == ROT_STGS - 1) begin : g_last
			assign nxt_rdy = dn_ready;
		end else begin : g_inner
			assign nxt_rdy = rdy[k+1];
		end

		// a stage takes new data when empty or when its content moves on
		assign rdy[k] = !vld_s[k] || nxt_rdy;

		// iterations of this stage
		always_comb begin
			nxt_d = in_d;
			for (int j = 0; j < ITERS_PER_STG; j++) begin
				nxt_d = cordic_iter(nxt_d, k * ITERS_PER_STG + j);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				vld_s[k] <= in_v;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k] && in_v) begin
				data_s[k] <= nxt_d;
			end
		end
	end

	assign up_ready = rdy[0];
	assign dn_valid = vld_s[ROT_STGS-1];
	assign dn_data  = data_s[ROT_STGS-1];

endmodule

`default_nettype wire

>>> src/polar_to_cartesian_rotator.sv
// Top level of the polar to Cartesian rotator: angle fold and gain multiply,
// CORDIC rotation pipeline, rounding and output register.
// Depends on pcr_pkg, pcr_if (pcr_polar_if, pcr_cart_if) and pcr_cordic.
//
//   channel  role    payload                              transaction
//   polar    sink    radius, angle, height                valid && ready
//   cart     source  x_coord, y_coord, z_coord            valid && ready
//
// One transaction per cycle sustained while cart.ready stays high; the stages are
// fold and multiply, 12 rotation stages of two iterations, and rounding.
// Every stage has its own valid bit and fills when empty, so bubbles close up
// and the input stays ready while a result waits, until all 14 stages hold data.
// arst_n clears the valid bits only; the data registers are not reset.
`default_nettype none

module polar_to_cartesian_rotator
	import pcr_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	pcr_polar_if.sink polar,
	pcr_cart_if.source cart
);

	// front stage: fold angle into a half turn around zero, scale radius by gain
	logic                 vld_s1;
	logic [PW-1:0]        prod_s1;
	logic                 neg_s1;
	logic signed [ZW-1:0] z_s1;
	logic signed [HW-1:0] h_s1;
	logic                 rdy_s1;

	logic                 fold;
	logic signed [AW-1:0] ang_fold;

	logic                 cor_up_ready;
	rot_t                 cor_up_data;
	logic signed [DW-1:0] x_pos;
	logic                 cor_dn_valid;
	rot_t                 cor_dn_data;

	logic                 res_vld_q;
	logic                 res_rdy;
	logic signed [OW-1:0] res_x_q;
	logic signed [OW-1:0] res_y_q;
	logic signed [HW-1:0] res_z_q;

	// adding a half turn modulo a full turn is an MSB flip
	assign fold     = (polar.angle > QUARTER_POS) || (polar.angle < QUARTER_NEG);
	assign ang_fold = fold ? {~polar.angle[AW-1], polar.angle[AW-2:0]} : polar.angle;

	assign rdy_s1      = !vld_s1 || cor_up_ready;
	assign polar.ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (rdy_s1) begin
			vld_s1 <= polar.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && polar.valid) begin
			prod_s1 <= PW'(polar.radius) * PW'(GAIN_Q30);
			neg_s1  <= fold;
			z_s1    <= {{(ZW-AW-ZSH){ang_fold[AW-1]}}, ang_fold, {ZSH{1'b0}}};
			h_s1    <= polar.height;
		end
	end

	// start vector, negated when the angle was folded
	assign x_pos           = {{(DW-PW){1'b0}}, prod_s1};
	assign cor_up_data.x   = neg_s1 ? -x_pos : x_pos;
	assign cor_up_data.y   = '0;
	assign cor_up_data.z   = z_s1;
	assign cor_up_data.h   = h_s1;

	pcr_cordic u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (vld_s1),
		.up_ready (cor_up_ready),
		.up_data  (cor_up_data),
		.dn_valid (cor_dn_valid),
		.dn_ready (res_rdy),
		.dn_data  (cor_dn_data)
	);

	// output register with rounding
	assign res_rdy = !res_vld_q || cart.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (res_rdy) begin
			res_vld_q <= cor_dn_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_rdy && cor_dn_valid) begin
			res_x_q <= round_clamp(cor_dn_data.x);
			res_y_q <= round_clamp(cor_dn_data.y);
			res_z_q <= cor_dn_data.h;
		end
	end

	assign cart.valid   = res_vld_q;
	assign cart.x_coord = res_x_q;
	assign cart.y_coord = res_y_q;
	assign cart.z_coord = res_z_q;

endmodule

`default_nettype wire

>>> src/pcr_checker.sv
// Port-level checks for polar_to_cartesian_rotator and the bind that
// attaches them. Depends on pcr_pkg and the top level.
`default_nettype none

module pcr_checker
	import pcr_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic signed [OW-1:0] x_coord,
	input wire logic signed [OW-1:0] y_coord
);

	localparam int CW = $clog2(PIPE_DEPTH + 1) + 1;

	logic [CW-1:0] cnt_q;
	logic          in_acc;
	logic          out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// transactions inside the block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + CW'(in_acc) - CW'(out_acc);
		end
	end

	// a stalled result stays offered and unchanged
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(x_coord) && $stable(y_coord))
		else $error("result dropped or changed under stall");

	// no result without an item inside
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> cnt_q != '0)
		else $error("result with no item in flight");

	// the pipeline holds at most one item per stage
	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(PIPE_DEPTH))
		else $error("more items in flight than stages");

	// results never hit the one code outside +/-65535
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> x_coord != 17'sh10000 && y_coord != 17'sh10000)
		else $error("result out of range");

endmodule

bind polar_to_cartesian_rotator pcr_checker u_pcr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (polar.valid),
	.in_ready  (polar.ready),
	.out_valid (cart.valid),
	.out_ready (cart.ready),
	.x_coord   (cart.x_coord),
	.y_coord   (cart.y_coord)
);

`default_nettype wire
